/* src/lobm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_pkg
// Types, codes and defaults shared by the order book matcher and its cells.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int DEFAULT_BOOK_DEPTH = 64;

  localparam logic [1:0] FN_LIMIT  = 2'd0;
  localparam logic [1:0] FN_MARKET = 2'd1;
  localparam logic [1:0] FN_CANCEL = 2'd2;
  localparam logic [1:0] FN_SPARE  = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NO_MATCH  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [23:0] limit_price;
    logic [15:0] quantity;
    logic [31:0] cancel_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] assigned_id;
    logic [31:0] matched_id;
    logic [23:0] trade_price;
    logic [15:0] traded_qty;
    logic [15:0] market_left_qty;
  } rsp_t;

  // A request travelling along the row of cells, with its result so far.
  typedef struct packed {
    logic  valid;
    logic  done;
    req_t  req;
    rsp_t  rsp;
  } tok_t;

endpackage : lobm_pkg
`default_nettype wire

/* src/lobm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lobm_cell
// One book entry. Serves the request passing by, then hands it to the next cell.
// ----------------------------------------------------------------------------
module lobm_cell
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH,
  parameter int CELL_IDX   = 0,
  localparam int CNT_W     = $clog2(BOOK_DEPTH + 1)
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire [CNT_W-1:0]  count,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  localparam logic [CNT_W-1:0] KIDX = CNT_W'(CELL_IDX);

  logic [31:0] id_r, id_nxt;
  logic [23:0] price_r, price_nxt;
  logic [15:0] qty_r, qty_nxt;
  logic        filled_r, filled_nxt;
  logic        cancelled_r, cancelled_nxt;
  tok_t        tok_r, tok_nxt;

  logic        in_book;
  logic        live;
  logic        active;
  logic [15:0] trade_q;

  assign in_book = KIDX < count;
  assign live    = in_book && !filled_r && !cancelled_r;
  assign active  = tok_i.valid && !tok_i.done;
  assign trade_q = (tok_i.req.quantity < qty_r) ? tok_i.req.quantity : qty_r;

  always_comb begin
    id_nxt        = id_r;
    price_nxt     = price_r;
    qty_nxt       = qty_r;
    filled_nxt    = filled_r;
    cancelled_nxt = cancelled_r;
    tok_nxt       = tok_i;
    if (active) begin
      unique case (tok_i.req.func)
        FN_LIMIT: begin
          if (KIDX == count) begin
            id_nxt        = tok_i.rsp.assigned_id;
            price_nxt     = tok_i.req.limit_price;
            qty_nxt       = tok_i.req.quantity;
            filled_nxt    = 1'b0;
            cancelled_nxt = 1'b0;
            tok_nxt.done  = 1'b1;
          end
        end
        FN_MARKET: begin
          if (live) begin
            qty_nxt                     = qty_r - trade_q;
            filled_nxt                  = 1'b1;
            tok_nxt.done                = 1'b1;
            tok_nxt.rsp.status          = ST_DONE;
            tok_nxt.rsp.matched_id      = id_r;
            tok_nxt.rsp.trade_price     = price_r;
            tok_nxt.rsp.traded_qty      = trade_q;
            tok_nxt.rsp.market_left_qty = tok_i.req.quantity - trade_q;
          end
        end
        FN_CANCEL: begin
          if (live && (id_r == tok_i.req.cancel_id)) begin
            cancelled_nxt      = 1'b1;
            tok_nxt.done       = 1'b1;
            tok_nxt.rsp.status = ST_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    price_r     <= price_nxt;
    qty_r       <= qty_nxt;
    filled_r    <= filled_nxt;
    cancelled_r <= cancelled_nxt;
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule : lobm_cell
`default_nettype wire

/* src/limit_order_book_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Order book of resting limit orders with market matching and cancels.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each book entry lives
// in one cell of a row of BOOK_DEPTH cells, and every request walks the whole
// row, one cell per cycle, so its single result beat appears on out_data with
// out_valid high for one cycle, once it has passed the head register and every
// cell register. busy falls the cycle after the result beat, so a new request
// is taken only once the last one's result beat has appeared. The receiver
// cannot stall and must take every result beat as it appears.
// ----------------------------------------------------------------------------
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  output logic  busy,
  input  req_t  in_data,
  output logic  out_valid,
  output rsp_t  out_data
);

  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BOOK_DEPTH);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      next_id_r, next_id_nxt;
  logic             busy_r, busy_nxt;
  tok_t             head_r, head_nxt;
  tok_t             chain [BOOK_DEPTH+1];
  logic             accept;
  tok_t             tail;

  assign accept = start && !busy_r;
  assign tail   = chain[BOOK_DEPTH];

  always_comb begin
    head_nxt       = head_r;
    head_nxt.valid = 1'b0;
    next_id_nxt    = next_id_r;
    if (accept) begin
      head_nxt.valid = 1'b1;
      head_nxt.done  = 1'b0;
      head_nxt.req   = in_data;
      head_nxt.rsp   = '0;
      unique case (in_data.func)
        FN_LIMIT: begin
          if (count_r == DEPTH_CNT) begin
            head_nxt.done       = 1'b1;
            head_nxt.rsp.status = ST_FULL;
          end else begin
            head_nxt.rsp.assigned_id = next_id_r;
            next_id_nxt              = next_id_r + 32'd1;
          end
        end
        FN_MARKET: begin
          head_nxt.rsp.status          = ST_NO_MATCH;
          head_nxt.rsp.assigned_id     = next_id_r;
          head_nxt.rsp.market_left_qty = in_data.quantity;
          next_id_nxt                  = next_id_r + 32'd1;
        end
        FN_CANCEL: begin
          head_nxt.rsp.status = ST_NOT_FOUND;
        end
        default: begin
          head_nxt.done = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    count_nxt = count_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (tail.valid) begin
      busy_nxt = 1'b0;
    end
    if (tail.valid && (tail.req.func == FN_LIMIT) && (tail.rsp.status == ST_DONE)) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      next_id_r    <= 32'd1;
      busy_r       <= 1'b0;
      head_r.valid <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      busy_r    <= busy_nxt;
      head_r    <= head_nxt;
    end
  end

  assign chain[0] = head_r;

  for (genvar k = 0; k < BOOK_DEPTH; k++) begin : g_cell
    lobm_cell #(
      .BOOK_DEPTH (BOOK_DEPTH),
      .CELL_IDX   (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .count (count_r),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  assign busy      = busy_r;
  assign out_valid = tail.valid;
  assign out_data  = tail.rsp;

`ifndef SYNTHESIS
  a_result_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result beat without a request in flight");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && !out_valid))
    else $error("result beat in the cycle after a request was taken");

  a_free_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy_r)
    else $error("busy still high after the result beat");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("book entry count beyond book depth");
`endif

endmodule : limit_order_book_matcher
`default_nettype wire

/* verif/lobm_match_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_match_checker
// Watches the request and result channels of the order book matcher, keeps
// its own copy of the book, works out the result of every accepted request
// and compares each result beat, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module lobm_match_checker
  import lobm_pkg::*;
#(
  parameter int BOOK_DEPTH = DEFAULT_BOOK_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  req_t in_data,
  input  logic out_valid,
  input  rsp_t out_data,
  output int   errors,
  output int   pending
);

  logic [31:0] book_id        [BOOK_DEPTH];
  logic [23:0] book_price     [BOOK_DEPTH];
  logic [15:0] book_qty       [BOOK_DEPTH];
  logic        book_filled    [BOOK_DEPTH];
  logic        book_cancelled [BOOK_DEPTH];
  int          book_count;
  logic [31:0] id_counter;
  rsp_t        owed_rsps[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic rsp_t apply_request(input req_t r);
    rsp_t        a;
    logic [15:0] q;
    bit          found;
    a     = '0;
    found = 1'b0;
    case (r.func)
      FN_LIMIT: begin
        if (book_count >= BOOK_DEPTH) begin
          a.status = ST_FULL;
        end else begin
          a.assigned_id              = id_counter;
          id_counter                 = id_counter + 32'd1;
          book_id[book_count]        = a.assigned_id;
          book_price[book_count]     = r.limit_price;
          book_qty[book_count]       = r.quantity;
          book_filled[book_count]    = 1'b0;
          book_cancelled[book_count] = 1'b0;
          book_count++;
        end
      end
      FN_MARKET: begin
        a.assigned_id     = id_counter;
        id_counter        = id_counter + 32'd1;
        a.status          = ST_NO_MATCH;
        a.market_left_qty = r.quantity;
        for (int k = 0; k < book_count && !found; k++) begin
          if (!book_filled[k] && !book_cancelled[k]) begin
            found             = 1'b1;
            q                 = (r.quantity < book_qty[k]) ? r.quantity : book_qty[k];
            a.status          = ST_DONE;
            a.traded_qty      = q;
            a.market_left_qty = r.quantity - q;
            a.matched_id      = book_id[k];
            a.trade_price     = book_price[k];
            book_qty[k]       = book_qty[k] - q;
            book_filled[k]    = 1'b1;
          end
        end
      end
      FN_CANCEL: begin
        a.status = ST_NOT_FOUND;
        for (int k = 0; k < book_count && !found; k++) begin
          if (book_id[k] == r.cancel_id && !book_filled[k] && !book_cancelled[k]) begin
            found             = 1'b1;
            a.status          = ST_DONE;
            book_cancelled[k] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      book_count = 0;
      id_counter = 32'd1;
      owed_rsps.delete();
    end else begin
      if (out_valid) begin
        if (owed_rsps.size() == 0) begin
          $error("result beat with nothing owed: %p", out_data);
          errors++;
        end else begin
          want = owed_rsps.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("assigned_id", want.assigned_id, out_data.assigned_id);
          check_field("matched_id", want.matched_id, out_data.matched_id);
          check_field("trade_price", want.trade_price, out_data.trade_price);
          check_field("traded_qty", want.traded_qty, out_data.traded_qty);
          check_field("market_left_qty", want.market_left_qty, out_data.market_left_qty);
        end
      end
      if (start && !busy) begin
        owed_rsps.insert(owed_rsps.size(), apply_request(in_data));
      end
    end
    pending = owed_rsps.size();
  end

endmodule : lobm_match_checker

/* verif/limit_order_book_matcher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher_tb
// Drives the order book matcher with a directed run through every request
// kind and several corners, then with random bursts of requests, and reports the
// verdict from the failures counted by the match checker.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_tb;
  import lobm_pkg::*;

  localparam int BOOK_DEPTH     = DEFAULT_BOOK_DEPTH;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int WATCHDOG_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t in_data = '0;
  logic busy;
  logic out_valid;
  rsp_t out_data;
  int   fault_count;
  int   outstanding;
  int   idle_cycles = 0;

  logic [31:0] id_guess = 32'd1;
  int          limits_placed = 0;
  logic [31:0] placed_ids[$];
  int          items_sent = 0;

  limit_order_book_matcher #(
    .BOOK_DEPTH(BOOK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  lobm_match_checker #(
    .BOOK_DEPTH(BOOK_DEPTH)
  ) i_match_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .errors   (fault_count),
    .pending  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("limit_order_book_matcher_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(input logic [1:0] f, input logic [23:0] price,
                                    input logic [15:0] qty, input logic [31:0] cid);
    req_t r;
    r.func        = f;
    r.limit_price = price;
    r.quantity    = qty;
    r.cancel_id   = cid;
    return r;
  endfunction

  function automatic req_t random_fill();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return req_t'(raw[$bits(req_t)-1:0]);
  endfunction

  // Holds the beat until the block takes it, and tracks the ids it hands out
  // so that later cancels can aim at real orders.
  task automatic issue(input req_t r);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    if (r.func == FN_LIMIT && limits_placed < BOOK_DEPTH) begin
      placed_ids.insert(placed_ids.size(), id_guess);
      id_guess = id_guess + 32'd1;
      limits_placed++;
    end else if (r.func == FN_MARKET) begin
      id_guess = id_guess + 32'd1;
    end
    items_sent++;
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= random_fill();
    end
  endtask

  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    int unsigned n;
    int unsigned sel;
    r    = random_fill();
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 7) == 0) r.quantity = 16'($urandom_range(0, 3));
    if (pick < 15) begin
      r.func = FN_LIMIT;
    end else if (pick < 35) begin
      r.func = FN_MARKET;
    end else if (pick < 92) begin
      r.func = FN_CANCEL;
      n      = placed_ids.size();
      if (n > 0) begin
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          r.cancel_id = placed_ids[n - 1 - $urandom_range(0, (n > 4) ? 3 : n - 1)];
        end else if (sel < 7) begin
          r.cancel_id = placed_ids[$urandom_range(0, n - 1)];
        end
      end
    end else begin
      r.func = FN_SPARE;
    end
    return r;
  endfunction

  initial begin
    int burst;
    bit steady;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(make_req(FN_MARKET, 24'd0, 16'd25, 32'd0));
    issue(make_req(FN_CANCEL, 24'd0, 16'd0, 32'd5));
    issue(make_req(FN_SPARE, 24'd0, 16'd0, 32'd0));
    issue(make_req(FN_LIMIT, 24'd0, 16'd0, 32'd0));
    issue(make_req(FN_LIMIT, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF));
    issue(make_req(FN_LIMIT, 24'd1234, 16'd100, 32'd0));
    issue(make_req(FN_LIMIT, 24'd98765, 16'd50, 32'd0));
    issue(make_req(FN_MARKET, 24'd0, 16'd0, 32'd0));
    issue(make_req(FN_MARKET, 24'd0, 16'hFFFF, 32'd0));
    issue(make_req(FN_MARKET, 24'd0, 16'd30, 32'd0));
    issue(make_req(FN_CANCEL, 24'd0, 16'd0, 32'd5));
    issue(make_req(FN_CANCEL, 24'd0, 16'd0, 32'd5));
    issue(make_req(FN_CANCEL, 24'd0, 16'd0, 32'd4));
    issue(make_req(FN_MARKET, 24'd0, 16'd10, 32'd0));
    issue(make_req(FN_LIMIT, 24'd500, 16'd200, 32'd0));
    issue(make_req(FN_CANCEL, 24'd0, 16'd0, 32'd0));
    issue(make_req(FN_CANCEL, 24'd0, 16'd0, 32'hFFFFFFFF));
    issue(make_req(FN_MARKET, 24'd0, 16'hFFFF, 32'd0));
    issue(make_req(FN_LIMIT, 24'hFFFFFF, 16'd1, 32'd0));
    issue(make_req(FN_MARKET, 24'd0, 16'd1, 32'd0));
    issue(make_req(FN_SPARE, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF));

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      burst  = steady ? $urandom_range(10, 30) : $urandom_range(1, 8);
      repeat (burst) issue(random_req());
      if (!steady || $urandom_range(0, 1) == 0) hold_off($urandom_range(1, 90));
    end

    hold_off(1);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * (BOOK_DEPTH + 2)) @(posedge clk);
    if (fault_count == 0) begin
      $display("limit_order_book_matcher_tb: clean");
    end else begin
      $display("limit_order_book_matcher_tb: errors");
    end
    $finish;
  end

endmodule : limit_order_book_matcher_tb
